[src/assert_macros.svh]
// assertion macros used by the top-level filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked property, skipped while reset is asserted
`define FRDF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked property, checked during reset too
`define FRDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FRDF_ASSERT(lbl, clk, rstn, prop, msg)
`define FRDF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[src/frdf_pkg.sv]
package frdf_pkg;

    // duplicate cache geometry
    localparam int CACHE_ENTRIES = 20;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    // frame header checks
    localparam logic [7:0] HEADER_BYTES      = 8'd22;
    localparam logic [7:0] RESET_MAGIC_FIRST = 8'd77;
    localparam logic [7:0] RESET_MAGIC_SECOND = 8'd82;

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic {
        REG_MAGIC_FIRST  = 1'b0,
        REG_MAGIC_SECOND = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] magic_second;
        logic [7:0] magic_first;
    } cfg_t;

    typedef enum logic [2:0] {
        V_NOT_DONE  = 3'd0,
        V_CRC_ERR   = 3'd1,
        V_SHORT     = 3'd2,
        V_BAD_MAGIC = 3'd3,
        V_DUPLICATE = 3'd4,
        V_EXPIRED   = 3'd5,
        V_FORWARD   = 3'd6
    } verdict_t;

    // one cache entry: id and source pair
    typedef struct packed {
        logic [55:0] source;
        logic [15:0] id;
    } cache_entry_t;

endpackage

[src/frdf_cache_mem.sv]
module frdf_cache_mem (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [frdf_pkg::IDX_W-1:0] waddr,
    input  frdf_pkg::cache_entry_t     wdata,
    input  logic [frdf_pkg::IDX_W-1:0] raddr,
    output frdf_pkg::cache_entry_t     rdata
);
    import frdf_pkg::*;

    cache_entry_t mem [CACHE_ENTRIES];
    cache_entry_t rdata_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/frdf_cfg_regs.sv]
module frdf_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [frdf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [frdf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output frdf_pkg::cfg_t                  cfg
);
    import frdf_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t wr_idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[2]);

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_first  <= RESET_MAGIC_FIRST;
            cfg_reg.magic_second <= RESET_MAGIC_SECOND;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_MAGIC_FIRST:  cfg_reg.magic_first  <= pwdata[7:0];
                REG_MAGIC_SECOND: cfg_reg.magic_second <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (wr_idx)
            REG_MAGIC_FIRST:  prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.magic_first};
            REG_MAGIC_SECOND: prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.magic_second};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[src/flood_relay_dedupe_filter.sv]
// packets dropped by the header checks go from the idle state straight to the emit state;
// packets that pass them first scan all CACHE_ENTRIES entries of the duplicate cache
// a new packet is accepted only after the previous result is loaded; the scan reads the
//   cache memory read port one entry per cycle
// reset: synchronous active-low aresetn clears valid bits, ring pointer and fsm, and presets
//   the magic regs; cache memory is not cleared, entries are gated by their valid bits
`include "assert_macros.svh"

module flood_relay_dedupe_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // byte_count[7:0], magic_byte_a[15:8], magic_byte_b[23:16], hop_limit[31:24],
    // message_id[47:32], source_name[103:48]
    input  logic [frdf_pkg::S_TDATA_W-1:0]  s_tdata,
    // rx_done[0], crc_error[1]
    input  logic [frdf_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // forward_hops[7:0]
    output logic [frdf_pkg::M_TDATA_W-1:0]  m_tdata,
    // verdict[2:0]
    output logic [frdf_pkg::M_TUSER_W-1:0]  m_tuser,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [frdf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [frdf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [frdf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import frdf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t            state_reg;
    cfg_t              cfg;

    // latched packet
    cache_entry_t      item_reg;
    logic [7:0]        hops_reg;
    verdict_t          verdict_reg;
    logic              insert_reg;

    // scan pipeline
    logic [IDX_W-1:0]  addr_reg;
    logic              issue_reg;
    logic              cmp_valid_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              hit_reg;

    // cache bookkeeping
    logic              valid_reg [CACHE_ENTRIES];
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_next;

    // result register
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    verdict_t          m_tuser_reg;

    cache_entry_t      rd_entry;
    cache_entry_t      in_entry;
    logic              in_done;
    logic              in_crc;
    logic [7:0]        in_count;
    logic [7:0]        in_ma;
    logic [7:0]        in_mb;
    logic [7:0]        in_hops;
    logic              s_fire;
    logic              out_free;
    logic              cmp_hit;
    logic              scan_last;
    logic              mem_we;

    frdf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    frdf_cache_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (ptr_reg),
        .wdata (item_reg),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    // input field unpacking
    assign in_done         = s_tuser[0];
    assign in_crc          = s_tuser[1];
    assign in_count        = s_tdata[7:0];
    assign in_ma           = s_tdata[15:8];
    assign in_mb           = s_tdata[23:16];
    assign in_hops         = s_tdata[31:24];
    assign in_entry.id     = s_tdata[47:32];
    assign in_entry.source = s_tdata[103:48];

    // handshake and scan helpers
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cmp_hit   = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_entry == item_reg);
    assign scan_last = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign mem_we    = (state_reg == S_EMIT) && out_free && insert_reg;
    assign ptr_next  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;

    // control fsm, scan pipeline and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            insert_reg    <= 1'b0;
            ptr_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            // result taken while no new one is loaded
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        item_reg   <= in_entry;
                        hops_reg   <= in_hops;
                        insert_reg <= 1'b0;
                        hit_reg    <= 1'b0;
                        addr_reg   <= '0;
                        // header checks in priority order
                        if (!in_done) begin
                            verdict_reg <= V_NOT_DONE;
                            state_reg   <= S_EMIT;
                        end else if (in_crc) begin
                            verdict_reg <= V_CRC_ERR;
                            state_reg   <= S_EMIT;
                        end else if (in_count < HEADER_BYTES) begin
                            verdict_reg <= V_SHORT;
                            state_reg   <= S_EMIT;
                        end else if (in_ma != cfg.magic_first ||
                                     in_mb != cfg.magic_second) begin
                            verdict_reg <= V_BAD_MAGIC;
                            state_reg   <= S_EMIT;
                        end else begin
                            issue_reg <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle
                    if (issue_reg) begin
                        if (addr_reg == LAST_IDX) begin
                            issue_reg <= 1'b0;
                        end else begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    // issue is already low by the last compare
                    cmp_valid_reg <= issue_reg;
                    cmp_idx_reg   <= addr_reg;
                    if (cmp_hit) begin
                        hit_reg <= 1'b1;
                    end
                    // last compare decides the verdict
                    if (scan_last) begin
                        state_reg <= S_EMIT;
                        if (hit_reg || cmp_hit) begin
                            verdict_reg <= V_DUPLICATE;
                            insert_reg  <= 1'b0;
                        end else begin
                            verdict_reg <= (hops_reg != 8'd0) ? V_FORWARD : V_EXPIRED;
                            insert_reg  <= 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= verdict_reg;
                        m_tdata_reg  <= (verdict_reg == V_FORWARD) ? hops_reg - 8'd1 : 8'd0;
                        if (insert_reg) begin
                            valid_reg[ptr_reg] <= 1'b1;
                            ptr_reg            <= ptr_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `FRDF_ASSERT(a_insert_only_new, aclk, aresetn,
        mem_we |-> (verdict_reg == V_FORWARD || verdict_reg == V_EXPIRED),
        "cache insert for a packet that is not new")
    `FRDF_ASSERT(a_ptr_in_range, aclk, aresetn,
        ptr_reg <= LAST_IDX, "ring pointer beyond last cache entry")
    `FRDF_ASSERT(a_insert_sets_valid, aclk, aresetn,
        mem_we |=> valid_reg[$past(ptr_reg)], "inserted entry not marked valid")
    `FRDF_ASSERT(a_result_from_emit, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EMIT),
        "result transaction raised outside emit state")
    `FRDF_ASSERT(a_no_accept_while_busy, aclk, aresetn,
        (state_reg != S_IDLE) |-> !s_tready, "input accepted during cache scan")

endmodule

[tb/tb_flood_relay_dedupe_filter.sv]
`timescale 1ns / 100ps

module tb_flood_relay_dedupe_filter;
    import frdf_pkg::*;

    localparam int          TOTAL_PACKETS = 1450;
    localparam int          N_DIR         = 20;
    localparam int          N_PHASES      = 4;
    localparam int          POOL_SIZE     = 32;
    localparam int          IDLE_LIMIT    = 3000;
    localparam int          TAIL_CYCLES   = 30;
    localparam int          PRINT_LIMIT   = 30;
    localparam logic [7:0]  MA            = RESET_MAGIC_FIRST;
    localparam logic [7:0]  MB            = RESET_MAGIC_SECOND;
    localparam logic [55:0] SRC_ONES      = 56'hFF_FFFF_FFFF_FFFF;
    localparam logic [55:0] SRC_TOP       = 56'h80_0000_0000_0000;

    // one received packet descriptor
    typedef struct packed {
        logic        done;
        logic        crc;
        logic [7:0]  cnt;
        logic [7:0]  ma;
        logic [7:0]  mb;
        logic [7:0]  hop;
        logic [15:0] id;
        logic [55:0] src;
    } pkt_t;

    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] hops;
    } verdict_rec_t;

    typedef struct packed {
        pkt_t         pkt;
        logic         typed;
        verdict_rec_t exp;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_pattern_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    flood_relay_dedupe_filter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state: magic bytes and the duplicate cache
    logic [7:0]  cur_magic_first  = MA;
    logic [7:0]  cur_magic_second = MB;
    logic [15:0] cached_ids     [CACHE_ENTRIES];
    logic [55:0] cached_sources [CACHE_ENTRIES];
    logic        cached_ok      [CACHE_ENTRIES];
    int          next_slot = 0;

    verdict_rec_t pending_verdicts[$];
    verdict_rec_t got_rec;
    verdict_rec_t exp_rec;
    int           err_count = 0;
    int           packets_sent = 0;
    int           verdict_seen [8];
    int           burst_left = 0;
    int           idle_cycles = 0;
    rx_pattern_t  rx_mode = RX_OPEN;
    int           rx_left = 0;
    logic [15:0]  pool_id  [POOL_SIZE];
    logic [55:0]  pool_src [POOL_SIZE];

    // directed table: header checks in order, empty cache, duplicates, hop extremes
    dir_row_t dir_rows [N_DIR] = '{
        '{'{1'b0, 1'b1, 8'd255, MA, MB, 8'd255, 16'hFFFF, SRC_ONES}, 1'b1, '{V_NOT_DONE, 8'd0}},
        '{'{1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 56'h0}, 1'b1, '{V_NOT_DONE, 8'd0}},
        '{'{1'b1, 1'b1, 8'd255, MA, MB, 8'd5, 16'h1234, 56'hAB}, 1'b1, '{V_CRC_ERR, 8'd0}},
        '{'{1'b1, 1'b0, 8'd0, MA, MB, 8'd5, 16'h1234, 56'hAB}, 1'b1, '{V_SHORT, 8'd0}},
        '{'{1'b1, 1'b0, 8'd21, MA, MB, 8'd5, 16'h1234, 56'hAB}, 1'b1, '{V_SHORT, 8'd0}},
        '{'{1'b1, 1'b0, 8'd22, 8'h6D, MB, 8'd5, 16'h1234, 56'hAB}, 1'b1, '{V_BAD_MAGIC, 8'd0}},
        '{'{1'b1, 1'b0, 8'd22, MA, 8'h00, 8'd5, 16'h1234, 56'hAB}, 1'b1, '{V_BAD_MAGIC, 8'd0}},
        '{'{1'b1, 1'b0, 8'd255, MB, MA, 8'd5, 16'h1234, 56'hAB}, 1'b1, '{V_BAD_MAGIC, 8'd0}},
        '{'{1'b1, 1'b0, 8'd22, MA, MB, 8'd0, 16'h0000, 56'h0}, 1'b1, '{V_EXPIRED, 8'd0}},
        '{'{1'b1, 1'b0, 8'd40, MA, MB, 8'd9, 16'h0000, 56'h0}, 1'b1, '{V_DUPLICATE, 8'd0}},
        '{'{1'b1, 1'b0, 8'd22, MA, MB, 8'd255, 16'h0000, 56'h1}, 1'b1, '{V_FORWARD, 8'd254}},
        '{'{1'b1, 1'b0, 8'd23, MA, MB, 8'd1, 16'h0001, 56'h0}, 1'b1, '{V_FORWARD, 8'd0}},
        '{'{1'b1, 1'b0, 8'd255, MA, MB, 8'd128, 16'hFFFF, SRC_ONES}, 1'b1,
          '{V_FORWARD, 8'd127}},
        '{'{1'b1, 1'b1, 8'd255, MA, MB, 8'd7, 16'hFFFF, SRC_ONES}, 1'b1, '{V_CRC_ERR, 8'd0}},
        '{'{1'b1, 1'b0, 8'd100, MA, MB, 8'd7, 16'hFFFF, SRC_ONES}, 1'b1,
          '{V_DUPLICATE, 8'd0}},
        '{'{1'b1, 1'b0, 8'd21, MA, MB, 8'd3, 16'h0000, 56'h0}, 1'b1, '{V_SHORT, 8'd0}},
        '{'{1'b0, 1'b0, 8'd22, MA, MB, 8'd3, 16'h0000, 56'h0}, 1'b1, '{V_NOT_DONE, 8'd0}},
        '{'{1'b1, 1'b0, 8'd60, MA, MB, 8'd2, 16'h8000, SRC_TOP}, 1'b0, '{V_NOT_DONE, 8'd0}},
        '{'{1'b1, 1'b0, 8'd61, MA, MB, 8'd0, 16'h8000, 56'h0}, 1'b0, '{V_NOT_DONE, 8'd0}},
        '{'{1'b1, 1'b0, 8'd62, MA, MB, 8'd200, 16'h8000, SRC_TOP}, 1'b0, '{V_NOT_DONE, 8'd0}}
    };

    // header checks, then cache lookup and insert at the ring slot
    function automatic verdict_rec_t classify_packet(input pkt_t p);
        verdict_rec_t r;
        logic         hit;
        r.verdict = V_NOT_DONE;
        r.hops    = 8'd0;
        hit       = 1'b0;
        if (!p.done) begin
            r.verdict = V_NOT_DONE;
        end else if (p.crc) begin
            r.verdict = V_CRC_ERR;
        end else if (p.cnt < HEADER_BYTES) begin
            r.verdict = V_SHORT;
        end else if (p.ma != cur_magic_first || p.mb != cur_magic_second) begin
            r.verdict = V_BAD_MAGIC;
        end else begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (cached_ok[i] && cached_ids[i] == p.id && cached_sources[i] == p.src)
                    hit = 1'b1;
            end
            if (hit) begin
                r.verdict = V_DUPLICATE;
            end else begin
                cached_ids[next_slot]     = p.id;
                cached_sources[next_slot] = p.src;
                cached_ok[next_slot]      = 1'b1;
                next_slot = (next_slot == CACHE_ENTRIES - 1) ? 0 : next_slot + 1;
                if (p.hop != 8'd0) begin
                    r.verdict = V_FORWARD;
                    r.hops    = p.hop - 8'd1;
                end else begin
                    r.verdict = V_EXPIRED;
                end
            end
        end
        return r;
    endfunction

    // random packet: mostly well-formed with pooled pairs, the rest with corrupted header fields
    function automatic pkt_t make_packet();
        pkt_t p;
        int   k;
        p.done = 1'b1;
        p.crc  = 1'b0;
        p.cnt  = ($urandom_range(0, 7) == 0) ? HEADER_BYTES : 8'($urandom_range(22, 255));
        p.ma   = cur_magic_first;
        p.mb   = cur_magic_second;
        p.hop  = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
        k      = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) begin
            p.id  = pool_id[k % POOL_SIZE];
            p.src = pool_src[k % POOL_SIZE];
        end else begin
            p.id  = 16'($urandom);
            p.src = 56'({$urandom, $urandom});
        end
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 4))
                0: begin
                    p.done = 1'b0;
                    p.crc  = 1'($urandom);
                    p.cnt  = 8'($urandom);
                end
                1: p.crc = 1'b1;
                2: p.cnt = 8'($urandom_range(0, 21));
                3: begin
                    if ($urandom_range(0, 2) != 0) p.ma = p.ma ^ 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 2) != 1) p.mb = p.mb ^ 8'($urandom_range(1, 255));
                end
                default: begin
                    p.done = 1'($urandom);
                    p.crc  = 1'($urandom);
                    p.cnt  = 8'($urandom);
                    p.ma   = 8'($urandom);
                    p.mb   = 8'($urandom);
                end
            endcase
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        if (err_count < PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, exp_val, got_val);
        err_count++;
    endtask

    // register write with a setup and an access phase, upper data bits carry junk
    task automatic write_magic(input reg_idx_t idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAGIC_FIRST) cur_magic_first = val;
        else cur_magic_second = val;
    endtask

    // one input transaction with bursty gaps ahead of it
    task automatic push_packet(input pkt_t p, input logic typed, input verdict_rec_t typed_exp);
        int           gap;
        verdict_rec_t pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {p.src, p.id, p.hop, p.mb, p.ma, p.cnt};
        s_tuser  <= {p.crc, p.done};
        do @(posedge aclk); while (!s_tready);
        pred = classify_packet(p);
        pending_verdicts.push_back(typed ? typed_exp : pred);
        packets_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    // receiver stall patterns
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_pattern_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rec.verdict = verdict_t'(m_tuser);
            got_rec.hops    = m_tdata;
            verdict_seen[m_tuser]++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result, verdict", 0, got_rec.verdict);
            end else begin
                exp_rec = pending_verdicts.pop_front();
                if (got_rec.verdict != exp_rec.verdict)
                    report_mismatch("verdict", exp_rec.verdict, got_rec.verdict);
                if (got_rec.hops != exp_rec.hops)
                    report_mismatch("forward_hops", exp_rec.hops, got_rec.hops);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     idle_cycles, pending_verdicts.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] phase_first  [N_PHASES];
        logic [7:0] phase_second [N_PHASES];
        int         per_phase;
        verdict_rec_t none;
        none = '{V_NOT_DONE, 8'd0};
        per_phase = (TOTAL_PACKETS - N_DIR) / N_PHASES;
        phase_first  = '{8'd0, 8'd255, 8'($urandom), MA};
        phase_second = '{8'd0, 8'd255, 8'($urandom), MB};
        for (int i = 0; i < CACHE_ENTRIES; i++) cached_ok[i] = 1'b0;
        for (int i = 0; i < 8; i++) verdict_seen[i] = 0;

        // pair pool: shared ids, shared sources and one-bit source neighbors
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_id[i]  = 16'($urandom);
            pool_src[i] = 56'({$urandom, $urandom});
            if (i % 4 == 1) pool_id[i] = pool_id[i-1];
            if (i % 4 == 2) pool_src[i] = pool_src[i-1];
            if (i % 4 == 3) begin
                pool_id[i]  = pool_id[i-1];
                pool_src[i] = pool_src[i-1] ^ (56'd1 << $urandom_range(0, 55));
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_magic(REG_MAGIC_FIRST, MA);
        write_magic(REG_MAGIC_SECOND, MB);

        // directed table
        for (int r = 0; r < N_DIR; r++)
            push_packet(dir_rows[r].pkt, dir_rows[r].typed, dir_rows[r].exp);
        drain_results();

        // random phases, one magic setting each
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_magic(REG_MAGIC_FIRST, phase_first[ph]);
            write_magic(REG_MAGIC_SECOND, phase_second[ph]);
            for (int n = 0; n < per_phase; n++) begin
                if (ph == 1 && n == per_phase / 2) drain_results();
                push_packet(make_packet(), 1'b0, none);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d packets over %0d magic settings plus reset values", packets_sent,
                 N_PHASES);
        $display("forwarded %0d, expired %0d, duplicates %0d, dropped by header checks %0d",
                 verdict_seen[V_FORWARD], verdict_seen[V_EXPIRED], verdict_seen[V_DUPLICATE],
                 verdict_seen[V_NOT_DONE] + verdict_seen[V_CRC_ERR] + verdict_seen[V_SHORT]
                 + verdict_seen[V_BAD_MAGIC]);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
